// File: hw/rtl/lcdns_pkg.sv
package lcdns_pkg;

    // Request codes on the command port.
    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_COMMAND    = 3'd1,
        CMD_DATA       = 3'd2,
        CMD_TEXT       = 3'd3,
        CMD_GOTO       = 3'd4,
        CMD_CGRAM      = 3'd5,
        CMD_SHOW_GLYPH = 3'd6,
        CMD_UNUSED     = 3'd7
    } cmd_t;

    localparam int unsigned WAIT_W = 15;
    localparam int unsigned STEP_W = 4;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

    // Register-select levels.
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Waits in microseconds.
    localparam logic [WAIT_W-1:0] GAP_US        = 15'd200;
    localparam logic [WAIT_W-1:0] TEXT_AFTER_US = 15'd2200;
    localparam logic [WAIT_W-1:0] GOTO_AFTER_US = 15'd320;
    localparam logic [WAIT_W-1:0] INIT_LOW_US   = 15'd1200;
    localparam logic [WAIT_W-1:0] POWER_UP_US   = 15'd30000;
    localparam logic [WAIT_W-1:0] WAKE_FIRST_US = 15'd20000;
    localparam logic [WAIT_W-1:0] WAKE_NEXT_US  = 15'd10300;
    localparam logic [WAIT_W-1:0] NO_WAIT_US    = 15'd0;

    // Addresses and limits.
    localparam logic [7:0] DDRAM_BASE   = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] COL_MAX      = 8'd15;
    localparam logic [7:0] SLOT_MAX     = 8'd7;

    // Final step index for each kind of job.
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;
    localparam logic [STEP_W-1:0] TWO_LAST_STEP  = 4'd3;
    localparam logic [STEP_W-1:0] ONE_LAST_STEP  = 4'd1;

    // One classified request, as held between front and back.
    typedef struct packed {
        logic              init;
        logic              two_bytes;
        logic              rs0;
        logic [7:0]        byte0;
        logic [WAIT_W-1:0] after0;
        logic              rs1;
        logic [7:0]        byte1;
    } job_t;

    // One enable strobe without its last marker.
    typedef struct packed {
        logic              rs;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] lead;
        logic [WAIT_W-1:0] after;
    } strobe_t;

    // The fixed power-up sequence, one strobe per step.
    function automatic strobe_t init_strobe(input logic [STEP_W-1:0] step);
        strobe_t s;
        s.rs     = RS_INSTR;
        s.lead   = NO_WAIT_US;
        s.after  = GAP_US;
        s.nibble = 4'h3;
        case (step)
            4'd0:
            begin
                s.lead   = POWER_UP_US;
                s.after  = WAKE_FIRST_US;
            end
            4'd1, 4'd2:  s.after = WAKE_NEXT_US;
            4'd3:        s.nibble = 4'h2;
            4'd4:        s.nibble = 4'h2;
            4'd5:
            begin
                s.nibble = 4'h8;
                s.after  = INIT_LOW_US;
            end
            4'd6:        s.nibble = 4'h0;
            4'd7:
            begin
                s.nibble = 4'h8;
                s.after  = INIT_LOW_US;
            end
            4'd8:        s.nibble = 4'h0;
            4'd9:
            begin
                s.nibble = 4'hF;
                s.after  = INIT_LOW_US;
            end
            4'd10:       s.nibble = 4'h0;
            4'd11:
            begin
                s.nibble = 4'h6;
                s.after  = INIT_LOW_US;
            end
            4'd12:       s.nibble = 4'h0;
            4'd13:
            begin
                s.nibble = 4'h1;
                s.after  = INIT_LOW_US;
            end
            default:     s.nibble = 4'h0;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/lcdns_front.sv
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic [2:0] command,
    input  logic [7:0] byte_value,
    input  logic [7:0] row,
    input  logic [7:0] col,
    input  logic [7:0] slot,
    output logic       job_valid,
    output job_t       job
);

    logic [7:0] col_sat;
    logic [7:0] goto_addr;
    logic [2:0] slot_clamp;
    logic [7:0] cgram_addr;

    // Cursor and character generator addresses.
    always_comb
    begin
        col_sat    = (col > COL_MAX) ? COL_MAX : col;
        goto_addr  = DDRAM_BASE + ((row == 8'd1) ? 8'h00 : LINE2_OFFSET) + col_sat;
        slot_clamp = (slot > SLOT_MAX) ? SLOT_MAX[2:0] : slot[2:0];
        cgram_addr = {2'b01, slot_clamp, 3'b000};
    end

    // Classify the request into a job for the back end.
    always_comb
    begin
        job_valid     = 1'b1;
        job.init      = 1'b0;
        job.two_bytes = 1'b0;
        job.rs0       = RS_INSTR;
        job.byte0     = byte_value;
        job.after0    = GAP_US;
        job.rs1       = RS_DATA;
        job.byte1     = slot;
        case (cmd_t'(command))
            CMD_INIT:    job.init = 1'b1;
            CMD_COMMAND: job.rs0 = RS_INSTR;
            CMD_DATA:    job.rs0 = RS_DATA;
            CMD_TEXT:
            begin
                job.rs0    = RS_DATA;
                job.after0 = TEXT_AFTER_US;
            end
            CMD_GOTO:
            begin
                job.byte0  = goto_addr;
                job.after0 = GOTO_AFTER_US;
            end
            CMD_CGRAM:   job.byte0 = cgram_addr;
            CMD_SHOW_GLYPH:
            begin
                job_valid     = (slot <= SLOT_MAX);
                job.two_bytes = 1'b1;
                job.byte0     = goto_addr;
                job.after0    = GOTO_AFTER_US;
            end
            default:     job_valid = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/lcdns_queue.sv
module lcdns_queue
    import lcdns_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t head_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign valid    = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/lcdns_back.sv
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_done,
    output logic              empty,
    input  logic              pop,
    output logic              reg_sel,
    output logic [3:0]        nibble,
    output logic [WAIT_W-1:0] wait_before_us,
    output logic [WAIT_W-1:0] wait_after_us,
    output logic              last
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    strobe_t           strobe_reg;
    logic              last_reg;
    strobe_t           cur;
    logic [STEP_W-1:0] last_step;
    logic              cur_last;
    logic              advance;
    logic              second_byte;
    logic              low_half;
    logic [7:0]        cur_byte;

    // Build the strobe for the current step of the head job.
    always_comb
    begin
        second_byte = step_reg[1];
        low_half    = step_reg[0];
        cur_byte    = second_byte ? job.byte1 : job.byte0;
        if (job.init)
        begin
            cur = init_strobe(step_reg);
        end
        else
        begin
            cur.rs     = second_byte ? job.rs1 : job.rs0;
            cur.nibble = low_half ? cur_byte[3:0] : cur_byte[7:4];
            cur.lead   = NO_WAIT_US;
            cur.after  = (low_half && !second_byte) ? job.after0 : GAP_US;
        end
        last_step = job.init ? INIT_LAST_STEP :
                    (job.two_bytes ? TWO_LAST_STEP : ONE_LAST_STEP);
        cur_last  = (step_reg == last_step);
    end

    // A strobe moves into the output register whenever that register is free.
    assign advance  = job_valid && (!out_valid_reg || pop);
    assign job_done = advance && cur_last;

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = cur_last ? '0 : step_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            strobe_reg <= cur;
            last_reg   <= cur_last;
        end
    end

    assign empty           = !out_valid_reg;
    assign reg_sel         = strobe_reg.rs;
    assign nibble          = strobe_reg.nibble;
    assign wait_before_us  = strobe_reg.lead;
    assign wait_after_us   = strobe_reg.after;
    assign last            = last_reg;

endmodule

// File: hw/rtl/char_lcd_nibble_sequencer.sv
// In an idle block a request is written into the queue, then its first strobe moves into
// the output register. The back end gives one strobe per cycle while the receiver pops:
// 2 strobes per byte request, 4 per show glyph, 14 per init, none for a dropped request.
// A request queue of QUEUE_DEPTH entries sits between the classifier and the sequencer.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        command,
    input  logic [7:0]        byte_value,
    input  logic [7:0]        row,
    input  logic [7:0]        col,
    input  logic [7:0]        slot,
    output logic              empty,
    input  logic              pop,
    output logic              reg_sel,
    output logic [3:0]        nibble,
    output logic [WAIT_W-1:0] wait_before_us,
    output logic [WAIT_W-1:0] wait_after_us,
    output logic              last
);

    logic front_valid;
    job_t front_job;
    logic head_valid;
    job_t head_job;
    logic head_done;

    // Classify the incoming request.
    lcdns_front u_front (
        .command    (command),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .slot       (slot),
        .job_valid  (front_valid),
        .job        (front_job)
    );

    // Requests that produce no strobe are accepted and dropped here.
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push && front_valid),
        .push_job (front_job),
        .full     (full),
        .pop      (head_done),
        .valid    (head_valid),
        .head_job (head_job)
    );

    // Step through the strobes of the oldest job.
    lcdns_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (head_valid),
        .job             (head_job),
        .job_done        (head_done),
        .empty           (empty),
        .pop             (pop),
        .reg_sel         (reg_sel),
        .nibble          (nibble),
        .wait_before_us  (wait_before_us),
        .wait_after_us   (wait_after_us),
        .last            (last)
    );

endmodule

// File: tb/tb_top.sv
module tb_top
    import lcdns_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int STALL_CYCLES  = 300;
    localparam int TAIL_CYCLES   = 20;
    localparam int IDLE_PERCENT  = 24;

    // Waits in microseconds, as the display controller expects them.
    localparam logic [14:0] US_NONE       = 15'd0;
    localparam logic [14:0] US_GAP        = 15'd200;
    localparam logic [14:0] US_POWER_UP   = 15'd30000;
    localparam logic [14:0] US_WAKE_FIRST = 15'd20000;
    localparam logic [14:0] US_WAKE_NEXT  = 15'd10300;
    localparam logic [14:0] US_INIT_EXTRA = 15'd1000;
    localparam logic [14:0] US_TEXT_EXTRA = 15'd2000;
    localparam logic [14:0] US_GOTO_EXTRA = 15'd120;

    localparam logic [7:0] ADDR_DDRAM  = 8'h80;
    localparam logic [7:0] ADDR_LINE2  = 8'h40;
    localparam logic [7:0] ADDR_CGRAM  = 8'h40;
    localparam logic [7:0] LAST_COLUMN = 8'd15;
    localparam logic [7:0] LAST_SLOT   = 8'd7;
    localparam logic [7:0] FIRST_ROW   = 8'd1;

    // One enable strobe as it should appear on the result ports.
    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [14:0] before_us;
        logic [14:0] after_us;
        logic        last_mark;
    } lcd_strobe_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  command;
    logic [7:0]  byte_value;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  slot;
    logic        empty;
    logic        pop;
    logic        reg_sel;
    logic [3:0]  nibble;
    logic [14:0] wait_before_us;
    logic [14:0] wait_after_us;
    logic        last;

    lcd_strobe_t pending_strobes[$];
    int          error_count;
    int          cycle_count;
    bit          idle_en;
    int          stall_req_count;

    char_lcd_nibble_sequencer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .byte_value      (byte_value),
        .row             (row),
        .col             (col),
        .slot            (slot),
        .empty           (empty),
        .pop             (pop),
        .reg_sel         (reg_sel),
        .nibble          (nibble),
        .wait_before_us  (wait_before_us),
        .wait_after_us   (wait_after_us),
        .last            (last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    // Watchdog: a run that stops making progress ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Append one strobe to the expected stream.
    function automatic void add_strobe(input logic rs_l, input logic [3:0] nib,
                                       input logic [14:0] bef, input logic [14:0] aft);
        lcd_strobe_t s;
        s.rs        = rs_l;
        s.nib       = nib;
        s.before_us = bef;
        s.after_us  = aft;
        s.last_mark = 1'b0;
        pending_strobes.push_back(s);
    endfunction

    // A byte always goes out high nibble first, with extra wait after the low one.
    function automatic void add_byte(input logic rs_l, input logic [7:0] b,
                                     input logic [14:0] extra);
        add_strobe(rs_l, b[7:4], US_NONE, US_GAP);
        add_strobe(rs_l, b[3:0], US_NONE, US_GAP + extra);
    endfunction

    function automatic logic [7:0] cursor_address(input logic [7:0] r, input logic [7:0] c);
        logic [7:0] c_sat;
        c_sat = (c > LAST_COLUMN) ? LAST_COLUMN : c;
        return ADDR_DDRAM + ((r == FIRST_ROW) ? 8'h00 : ADDR_LINE2) + c_sat;
    endfunction

    // Work out every strobe that one accepted request should produce.
    function automatic void predict_strobes(input cmd_t cmd, input logic [7:0] bv,
                                            input logic [7:0] r, input logic [7:0] c,
                                            input logic [7:0] s);
        logic [7:0] init_seq [5];
        logic [7:0] s_clamped;
        int         start_size;
        init_seq   = '{8'h28, 8'h08, 8'h0F, 8'h06, 8'h01};
        start_size = pending_strobes.size();
        s_clamped  = (s > LAST_SLOT) ? LAST_SLOT : s;
        case (cmd)
            CMD_INIT:
            begin
                add_strobe(RS_INSTR, 4'h3, US_POWER_UP, US_WAKE_FIRST);
                add_strobe(RS_INSTR, 4'h3, US_NONE, US_WAKE_NEXT);
                add_strobe(RS_INSTR, 4'h3, US_NONE, US_WAKE_NEXT);
                add_strobe(RS_INSTR, 4'h2, US_NONE, US_GAP);
                foreach (init_seq[i])
                begin
                    add_byte(RS_INSTR, init_seq[i], US_INIT_EXTRA);
                end
            end
            CMD_COMMAND: add_byte(RS_INSTR, bv, US_NONE);
            CMD_DATA:    add_byte(RS_DATA, bv, US_NONE);
            CMD_TEXT:    add_byte(RS_DATA, bv, US_TEXT_EXTRA);
            CMD_GOTO:    add_byte(RS_INSTR, cursor_address(r, c), US_GOTO_EXTRA);
            CMD_CGRAM:   add_byte(RS_INSTR, ADDR_CGRAM + s_clamped * 8'd8, US_NONE);
            CMD_SHOW_GLYPH:
            begin
                // A slot beyond the glyph store produces nothing at all.
                if (s <= LAST_SLOT)
                begin
                    add_byte(RS_INSTR, cursor_address(r, c), US_GOTO_EXTRA);
                    add_byte(RS_DATA, s, US_NONE);
                end
            end
            default:
            begin
            end
        endcase
        if (pending_strobes.size() > start_size)
        begin
            pending_strobes[pending_strobes.size() - 1].last_mark = 1'b1;
        end
    endfunction

    // Offer one request, wait for the transaction, then record what it should produce.
    task automatic send_request(input cmd_t cmd, input logic [7:0] bv, input logic [7:0] r,
                                input logic [7:0] c, input logic [7:0] s);
        int gap;
        gap = 0;
        if (idle_en && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        command    <= cmd;
        byte_value <= bv;
        row        <= r;
        col        <= c;
        slot       <= s;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_strobes(cmd, bv, r, c, s);
    endtask

    function automatic void check_field(input string fname, input logic [14:0] exp_v,
                                        input logic [14:0] act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Result side: check each transaction, then decide whether to take the next one.
    initial
    begin
        lcd_strobe_t exp_s;
        int          stall_left;
        int          stall_ack_count;
        pop             = 1'b0;
        stall_left      = 0;
        stall_ack_count = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_strobes.size() == 0)
                begin
                    $display("%0t: unexpected strobe, expected none, actual nibble %0h",
                             $time, nibble);
                    error_count++;
                end
                else
                begin
                    exp_s = pending_strobes.pop_front();
                    check_field("reg_sel", 15'(exp_s.rs), 15'(reg_sel));
                    check_field("nibble", 15'(exp_s.nib), 15'(nibble));
                    check_field("wait_before_us", exp_s.before_us, wait_before_us);
                    check_field("wait_after_us", exp_s.after_us, wait_after_us);
                    check_field("last", 15'(exp_s.last_mark), 15'(last));
                end
            end
            if (stall_ack_count != stall_req_count)
            begin
                stall_ack_count = stall_req_count;
                stall_left      = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_en)
            begin
                pop <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic test_init();
        send_request(CMD_INIT, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Command, data and text bytes at both extremes and a mixed pattern.
    task automatic test_byte_requests();
        send_request(CMD_COMMAND, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_COMMAND, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_TEXT, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_request(CMD_TEXT, 8'h5A, 8'h01, 8'h0F, 8'h07);
    endtask

    // Both lines, and columns beyond the end of the line.
    task automatic test_goto();
        send_request(CMD_GOTO, 8'h00, 8'd1, 8'd0, 8'h00);
        send_request(CMD_GOTO, 8'h00, 8'd0, 8'd15, 8'h00);
        send_request(CMD_GOTO, 8'h00, 8'd1, 8'd16, 8'h00);
        send_request(CMD_GOTO, 8'h00, 8'd255, 8'd255, 8'h00);
        send_request(CMD_GOTO, 8'h00, 8'd2, 8'd7, 8'h00);
    endtask

    // Slot select, with slots beyond seven clamped.
    task automatic test_cgram();
        send_request(CMD_CGRAM, 8'h00, 8'h00, 8'h00, 8'd0);
        send_request(CMD_CGRAM, 8'h00, 8'h00, 8'h00, 8'd7);
        send_request(CMD_CGRAM, 8'h00, 8'h00, 8'h00, 8'd8);
        send_request(CMD_CGRAM, 8'h00, 8'h00, 8'h00, 8'd255);
    endtask

    // Show glyph for valid slots, and the silent case for slots beyond seven.
    task automatic test_show_glyph();
        send_request(CMD_SHOW_GLYPH, 8'h00, 8'd1, 8'd3, 8'd0);
        send_request(CMD_SHOW_GLYPH, 8'h00, 8'd0, 8'd200, 8'd7);
        send_request(CMD_SHOW_GLYPH, 8'h00, 8'd1, 8'd0, 8'd8);
        send_request(CMD_SHOW_GLYPH, 8'hFF, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_unused_code();
        send_request(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic send_random_request();
        int         pick;
        cmd_t       cmd;
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            cmd = CMD_INIT;
        else if (pick < 18)
            cmd = CMD_COMMAND;
        else if (pick < 34)
            cmd = CMD_DATA;
        else if (pick < 50)
            cmd = CMD_TEXT;
        else if (pick < 64)
            cmd = CMD_GOTO;
        else if (pick < 76)
            cmd = CMD_CGRAM;
        else if (pick < 94)
            cmd = CMD_SHOW_GLYPH;
        else
            cmd = CMD_UNUSED;
        // Bias towards sensible cursor and slot values while still covering every bit.
        r = ($urandom_range(0, 1) == 0) ? FIRST_ROW : 8'($urandom_range(0, 255));
        c = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        s = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        send_request(cmd, 8'($urandom_range(0, 255)), r, c, s);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        idle_en = 1'b0;
        stall_req_count++;
        repeat (16) send_random_request();
        idle_en = 1'b1;
    endtask

    task automatic test_random_steady(input int count);
        idle_en = 1'b0;
        repeat (count) send_random_request();
        idle_en = 1'b1;
    endtask

    task automatic test_random_idle(input int count);
        idle_en = 1'b1;
        repeat (count) send_random_request();
    endtask

    // Main sequence: reset, directed requests, then random traffic.
    initial
    begin
        error_count     = 0;
        idle_en         = 1'b1;
        stall_req_count = 0;
        rst_n           = 1'b0;
        push            = 1'b0;
        command         = CMD_INIT;
        byte_value      = 8'h00;
        row             = 8'h00;
        col             = 8'h00;
        slot            = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_init();
        test_byte_requests();
        test_goto();
        test_cgram();
        test_show_glyph();
        test_unused_code();
        test_backpressure();
        test_random_steady(60);
        test_random_idle(180);

        push <= 1'b0;
        while (pending_strobes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
